@@ rtl/core/crlp_pkg.sv @@
// Shared constants, types and helpers for the channel run-length packer.
package crlp_pkg;

    localparam int MAX_LITERAL_DEF = 128;
    localparam int MAX_RUN_DEF = 130;

    localparam logic [7:0] RUN_HDR_BASE = 8'h80;
    localparam logic [7:0] MIN_RUN = 8'd3;

    typedef struct packed {
        logic       start_run;
        logic       start_lit;
        logic [7:0] hdr;
        logic [7:0] val;
        logic       finish;
        logic       fin_last;
    } emit_req_t;

    function automatic logic [7:0] run_header(input logic [7:0] n);
        return RUN_HDR_BASE + n - MIN_RUN;
    endfunction

endpackage

@@ rtl/core/crlp_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
module crlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = crlp_pkg::MAX_LITERAL_DEF
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/crlp_emit.sv @@
// Token emitter: packs run and literal tokens into output words of up to four bytes.
module crlp_emit #(
    parameter int MAX_LITERAL = crlp_pkg::MAX_LITERAL_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  crlp_pkg::emit_req_t                                   req,
    output logic                                                  busy,
    output logic [$clog2(MAX_LITERAL > 1 ? MAX_LITERAL : 2)-1:0]  ram_raddr,
    input  logic [7:0]                                            ram_rdata,
    output logic                                                  word_valid,
    input  logic                                                  word_ready,
    output logic [31:0]                                           out_word,
    output logic [2:0]                                            byte_count,
    output logic                                                  token_end,
    output logic                                                  stream_end
);

    localparam int AW = $clog2(MAX_LITERAL > 1 ? MAX_LITERAL : 2);

    typedef enum logic [5:0] {
        E_IDLE = 6'b000001,
        E_RUN0 = 6'b000010,
        E_RUN1 = 6'b000100,
        E_LITH = 6'b001000,
        E_LITB = 6'b010000,
        E_FIN  = 6'b100000
    } emit_state_t;

    emit_state_t      state_reg, state_next;
    logic [7:0]       tok_hdr_reg, tok_hdr_next;
    logic [7:0]       tok_val_reg, tok_val_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic             fin_last_reg, fin_last_next;
    logic [31:0]      hold_word_reg, hold_word_next;
    logic [2:0]       hold_cnt_reg, hold_cnt_next;
    logic             hold_tend_reg, hold_tend_next;
    logic             word_valid_reg, word_valid_next;
    logic [31:0]      out_word_reg, out_word_next;
    logic [2:0]       byte_count_reg, byte_count_next;
    logic             token_end_reg, token_end_next;
    logic             stream_end_reg, stream_end_next;

    logic             out_free;
    logic             hold_closed;
    logic             dep_ok;
    logic             dep_en;
    logic [7:0]       dep_byte;
    logic             dep_tend;
    logic             push;
    logic             push_stream;
    logic [31:0]      hold_base;

    always_comb
    begin
        state_next      = state_reg;
        tok_hdr_next    = tok_hdr_reg;
        tok_val_next    = tok_val_reg;
        rd_ptr_next     = rd_ptr_reg;
        fin_last_next   = fin_last_reg;
        hold_word_next  = hold_word_reg;
        hold_cnt_next   = hold_cnt_reg;
        hold_tend_next  = hold_tend_reg;
        word_valid_next = word_valid_reg;
        out_word_next   = out_word_reg;
        byte_count_next = byte_count_reg;
        token_end_next  = token_end_reg;
        stream_end_next = stream_end_reg;

        out_free    = !word_valid_reg || word_ready;
        hold_closed = (hold_cnt_reg == 3'd4) || ((hold_cnt_reg != 3'd0) && hold_tend_reg);
        dep_ok      = !hold_closed || out_free;
        dep_en      = 1'b0;
        dep_byte    = tok_hdr_reg;
        dep_tend    = 1'b0;
        push        = 1'b0;
        push_stream = 1'b0;
        hold_base   = (hold_cnt_reg == 3'd0) ? 32'h0 : hold_word_reg;

        case (state_reg)
            E_IDLE:
            begin
                if (req.start_run)
                begin
                    tok_hdr_next = req.hdr;
                    tok_val_next = req.val;
                    state_next   = E_RUN0;
                end
                else if (req.start_lit)
                begin
                    tok_hdr_next = req.hdr;
                    rd_ptr_next  = '0;
                    state_next   = E_LITH;
                end
                else if (req.finish && (hold_cnt_reg != 3'd0))
                begin
                    fin_last_next = req.fin_last;
                    state_next    = E_FIN;
                end
            end
            E_RUN0:
            begin
                dep_en   = 1'b1;
                dep_byte = tok_hdr_reg;
                if (dep_ok)
                begin
                    state_next = E_RUN1;
                end
            end
            E_RUN1:
            begin
                dep_en   = 1'b1;
                dep_byte = tok_val_reg;
                dep_tend = 1'b1;
                if (dep_ok)
                begin
                    state_next = E_IDLE;
                end
            end
            E_LITH:
            begin
                dep_en   = 1'b1;
                dep_byte = tok_hdr_reg;
                if (dep_ok)
                begin
                    state_next = E_LITB;
                end
            end
            E_LITB:
            begin
                dep_en   = 1'b1;
                dep_byte = ram_rdata;
                dep_tend = (rd_ptr_reg == tok_hdr_reg[AW-1:0]);
                if (dep_ok)
                begin
                    if (dep_tend)
                    begin
                        state_next = E_IDLE;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + AW'(1);
                    end
                end
            end
            E_FIN:
            begin
                if (out_free)
                begin
                    push          = 1'b1;
                    push_stream   = fin_last_reg;
                    hold_cnt_next = 3'd0;
                    state_next    = E_IDLE;
                end
            end
            default:
            begin
                state_next = E_IDLE;
            end
        endcase

        if (dep_en && dep_ok)
        begin
            if (hold_closed)
            begin
                push           = 1'b1;
                hold_word_next = {dep_byte, 24'h0};
                hold_cnt_next  = 3'd1;
            end
            else
            begin
                hold_word_next = hold_base | ({dep_byte, 24'h0} >> {hold_cnt_reg[1:0], 3'b000});
                hold_cnt_next  = hold_cnt_reg + 3'd1;
            end
            hold_tend_next = dep_tend;
        end

        if (push)
        begin
            word_valid_next = 1'b1;
            out_word_next   = hold_word_reg;
            byte_count_next = hold_cnt_reg;
            token_end_next  = hold_tend_reg;
            stream_end_next = push_stream;
        end
        else if (word_ready)
        begin
            word_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= E_IDLE;
            hold_cnt_reg   <= 3'd0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hold_cnt_reg   <= hold_cnt_next;
            word_valid_reg <= word_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_hdr_reg    <= tok_hdr_next;
        tok_val_reg    <= tok_val_next;
        rd_ptr_reg     <= rd_ptr_next;
        fin_last_reg   <= fin_last_next;
        hold_word_reg  <= hold_word_next;
        hold_tend_reg  <= hold_tend_next;
        out_word_reg   <= out_word_next;
        byte_count_reg <= byte_count_next;
        token_end_reg  <= token_end_next;
        stream_end_reg <= stream_end_next;
    end

    assign busy       = (state_reg != E_IDLE);
    assign ram_raddr  = rd_ptr_next;
    assign word_valid = word_valid_reg;
    assign out_word   = out_word_reg;
    assign byte_count = byte_count_reg;
    assign token_end  = token_end_reg;
    assign stream_end = stream_end_reg;

endmodule

@@ rtl/core/channel_run_length_packer.sv @@
// Top level of the channel run-length packer: byte sequencer, literal store and emitter.
// The packer takes one item, a byte of a channel, at a time and turns the channel into
// run and literal tokens, sent as words of up to four bytes with the earliest byte in the
// top bits. The emitter reads the literal store one byte per cycle, unless the output
// channel is stalled, through its single read port; the end of an item that produced
// words releases the final word. A stalled output channel holds the packer. Open literal
// bytes live in one 8-bit RAM of MAX_LITERAL entries, which needs no clearing after reset.
module channel_run_length_packer #(
    parameter int MAX_LITERAL = crlp_pkg::MAX_LITERAL_DEF,
    parameter int MAX_RUN     = crlp_pkg::MAX_RUN_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_of_channel,
    output logic        word_valid,
    input  logic        word_ready,
    output logic [31:0] out_word,
    output logic [2:0]  byte_count,
    output logic        token_end,
    output logic        stream_end
);

    localparam int AW = $clog2(MAX_LITERAL > 1 ? MAX_LITERAL : 2);
    localparam int LW = $clog2(MAX_LITERAL + 1);
    localparam int RW = $clog2(MAX_RUN + 1);

    typedef enum logic [4:0] {
        Q_IDLE   = 5'b00001,
        Q_STEP   = 5'b00010,
        Q_RUNFL  = 5'b00100,
        Q_CHKLIT = 5'b01000,
        Q_LAST   = 5'b10000
    } seq_state_t;

    seq_state_t          state_reg, state_next;
    logic [7:0]          byte_reg, byte_next;
    logic                last_reg, last_next;
    logic [LW-1:0]       lit_len_reg, lit_len_next;
    logic [7:0]          run_val_reg, run_val_next;
    logic [RW-1:0]       run_len_reg, run_len_next;
    logic [7:0]          held0_reg, held0_next;
    logic [7:0]          held1_reg, held1_next;
    logic [1:0]          held_cnt_reg, held_cnt_next;
    logic                run_mode_reg, run_mode_next;

    crlp_pkg::emit_req_t req;
    logic                busy;
    logic                ram_we;
    logic [7:0]          ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [7:0]          ram_rdata;

    always_comb
    begin
        seq_state_t follow;
        logic       started;

        follow        = Q_LAST;
        started       = 1'b0;
        state_next    = state_reg;
        byte_next     = byte_reg;
        last_next     = last_reg;
        lit_len_next  = lit_len_reg;
        run_val_next  = run_val_reg;
        run_len_next  = run_len_reg;
        held0_next    = held0_reg;
        held1_next    = held1_reg;
        held_cnt_next = held_cnt_reg;
        run_mode_next = run_mode_reg;
        req           = '0;
        ram_we        = 1'b0;
        ram_wdata     = held0_reg;

        case (state_reg)
            Q_IDLE:
            begin
                if (byte_valid)
                begin
                    byte_next  = data_byte;
                    last_next  = last_of_channel;
                    state_next = Q_STEP;
                end
            end
            Q_STEP:
            begin
                if (!busy)
                begin
                    if (run_mode_reg)
                    begin
                        if ((byte_reg == run_val_reg) && (run_len_reg < RW'(MAX_RUN)))
                        begin
                            run_len_next = run_len_reg + RW'(1);
                            if (run_len_reg == RW'(MAX_RUN - 1))
                            begin
                                req.start_run = 1'b1;
                                req.hdr       = crlp_pkg::run_header(8'(MAX_RUN));
                                req.val       = run_val_reg;
                                run_mode_next = 1'b0;
                                run_len_next  = '0;
                                started       = 1'b1;
                            end
                        end
                        else
                        begin
                            req.start_run = 1'b1;
                            req.hdr       = crlp_pkg::run_header(8'(run_len_reg));
                            req.val       = run_val_reg;
                            run_mode_next = 1'b0;
                            run_len_next  = '0;
                            held0_next    = byte_reg;
                            held_cnt_next = 2'd1;
                            started       = 1'b1;
                        end
                    end
                    else if (held_cnt_reg == 2'd2)
                    begin
                        if ((held0_reg == held1_reg) && (held1_reg == byte_reg))
                        begin
                            if (lit_len_reg != '0)
                            begin
                                req.start_lit = 1'b1;
                                req.hdr       = 8'(lit_len_reg - LW'(1));
                                lit_len_next  = '0;
                                started       = 1'b1;
                            end
                            run_mode_next = 1'b1;
                            run_val_next  = byte_reg;
                            run_len_next  = RW'(crlp_pkg::MIN_RUN);
                            held_cnt_next = 2'd0;
                            if (MAX_RUN <= int'(crlp_pkg::MIN_RUN))
                            begin
                                follow = Q_RUNFL;
                            end
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            ram_wdata    = held0_reg;
                            lit_len_next = lit_len_reg + LW'(1);
                            held0_next   = held1_reg;
                            held1_next   = byte_reg;
                            if (lit_len_reg == LW'(MAX_LITERAL - 1))
                            begin
                                follow = Q_CHKLIT;
                            end
                        end
                    end
                    else
                    begin
                        if (held_cnt_reg == 2'd0)
                        begin
                            held0_next = byte_reg;
                        end
                        else
                        begin
                            held1_next = byte_reg;
                        end
                        held_cnt_next = held_cnt_reg + 2'd1;
                    end

                    if (!started && (follow == Q_LAST) && !last_reg)
                    begin
                        req.finish   = 1'b1;
                        req.fin_last = 1'b0;
                        state_next   = Q_IDLE;
                    end
                    else
                    begin
                        state_next = follow;
                    end
                end
            end
            Q_RUNFL:
            begin
                if (!busy)
                begin
                    req.start_run = 1'b1;
                    req.hdr       = crlp_pkg::run_header(8'(run_len_reg));
                    req.val       = run_val_reg;
                    run_mode_next = 1'b0;
                    run_len_next  = '0;
                    state_next    = Q_LAST;
                end
            end
            Q_CHKLIT:
            begin
                if (!busy)
                begin
                    if (lit_len_reg == LW'(MAX_LITERAL))
                    begin
                        req.start_lit = 1'b1;
                        req.hdr       = 8'(lit_len_reg - LW'(1));
                        lit_len_next  = '0;
                    end
                    state_next = Q_LAST;
                end
            end
            Q_LAST:
            begin
                if (!busy)
                begin
                    if (!last_reg)
                    begin
                        req.finish   = 1'b1;
                        req.fin_last = 1'b0;
                        state_next   = Q_IDLE;
                    end
                    else if (run_mode_reg)
                    begin
                        req.start_run = 1'b1;
                        req.hdr       = crlp_pkg::run_header(8'(run_len_reg));
                        req.val       = run_val_reg;
                        run_mode_next = 1'b0;
                        run_len_next  = '0;
                    end
                    else if (held_cnt_reg != 2'd0)
                    begin
                        ram_we        = 1'b1;
                        ram_wdata     = held0_reg;
                        lit_len_next  = lit_len_reg + LW'(1);
                        held0_next    = held1_reg;
                        held_cnt_next = held_cnt_reg - 2'd1;
                        if (lit_len_reg == LW'(MAX_LITERAL - 1))
                        begin
                            state_next = Q_CHKLIT;
                        end
                    end
                    else if (lit_len_reg != '0)
                    begin
                        req.start_lit = 1'b1;
                        req.hdr       = 8'(lit_len_reg - LW'(1));
                        lit_len_next  = '0;
                    end
                    else
                    begin
                        req.finish   = 1'b1;
                        req.fin_last = 1'b1;
                        held0_next   = 8'h00;
                        held1_next   = 8'h00;
                        run_val_next = 8'h00;
                        run_len_next = '0;
                        state_next   = Q_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= Q_IDLE;
            lit_len_reg  <= '0;
            run_val_reg  <= 8'h00;
            run_len_reg  <= '0;
            held0_reg    <= 8'h00;
            held1_reg    <= 8'h00;
            held_cnt_reg <= 2'd0;
            run_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            lit_len_reg  <= lit_len_next;
            run_val_reg  <= run_val_next;
            run_len_reg  <= run_len_next;
            held0_reg    <= held0_next;
            held1_reg    <= held1_next;
            held_cnt_reg <= held_cnt_next;
            run_mode_reg <= run_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign byte_ready = (state_reg == Q_IDLE);

    crlp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LITERAL)
    ) u_lit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (lit_len_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    crlp_emit #(
        .MAX_LITERAL (MAX_LITERAL)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .busy       (busy),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .out_word   (out_word),
        .byte_count (byte_count),
        .token_end  (token_end),
        .stream_end (stream_end)
    );

endmodule

@@ rtl/core/crlp_check.sv @@
// Port-level checker for the channel run-length packer, bound to the top level.
module crlp_check (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_ready,
    input logic        word_valid,
    input logic        word_ready,
    input logic [31:0] out_word,
    input logic [2:0]  byte_count,
    input logic        token_end,
    input logic        stream_end
);

    // A word that does not close a token is always full.
    a_partial_word_closes_token: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !token_end |-> byte_count == 3'd4)
        else $error("partial word does not close its token");

    // The final word of a channel always closes a token.
    a_stream_end_on_token_end: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && stream_end |-> token_end)
        else $error("stream end on a word that does not close a token");

    // The byte count lies in its range and unused low bytes are zero.
    a_count_and_padding: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> (byte_count != 3'd0) && (byte_count <= 3'd4)
            && ((byte_count == 3'd4) || (out_word[7:0] == 8'h00))
            && ((byte_count >= 3'd3) || (out_word[15:8] == 8'h00))
            && ((byte_count >= 3'd2) || (out_word[23:16] == 8'h00)))
        else $error("bad byte count or non-zero padding");

    // Each item is worked on alone, so the input closes right after an accept.
    a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_ready |=> !byte_ready)
        else $error("input ready straight after an accepted item");

    a_word_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && !word_ready |=> word_valid && $stable(out_word)
            && $stable(byte_count) && $stable(token_end) && $stable(stream_end))
        else $error("output word changed while stalled");

endmodule

bind channel_run_length_packer crlp_check u_crlp_check (.*);
